// ----- design/crp_pkg.sv -----
// Package with the shared types and constants of the clock page replacement block.
package crp_pkg;

   localparam int PAGE_W  = 16;
   localparam int SLOT_W  = 4;
   localparam int FAULT_W = 16;
   localparam int CSR_W   = 5;

   localparam logic [CSR_W-1:0]   CSR_FRAMES_RESET = CSR_W'(3);
   localparam logic [FAULT_W-1:0] FAULT_MAX        = '1;

   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              last_reference;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [FAULT_W-1:0] fault_count;
      logic               last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_LOAD,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan_next;
      logic hit_done;
      logic sweep;
      logic load;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic match;
      logic scan_end;
      logic ref_set;
      logic out_free;
   } status_type;

endpackage

// ----- design/clock_page_replacement.sv -----
// Top level of the clock (second-chance) page replacement block.
//
// Usage: each transaction on the req_ channel carries one page reference.
// The block searches the managed frames for the page in frame order. On a
// hit it sets that frame's reference bit; on a miss the clock hand sweeps
// forward, clearing set reference bits, loads the page into the first frame
// with a clear bit, counts a fault and advances the hand. One transaction
// leaves on the rsp_ channel per reference. csr_wr_en writes the number of
// managed frames; write it only while the block is idle.
// A hit is found by a serial frame scan over the single read port of the
// frame RAM; a miss scans all managed frames before the sweep, which moves
// one frame per cycle and clears each set reference bit it passes. The next
// reference is accepted once the result has moved into the output register,
// at the earliest in the cycle in which that result is first presented, so
// one reference is in work at a time.
// Reset clears all frames, the hand, the fault count and sets the frame
// count to three. If the receiver stalls, the result waits in the output
// register and the next reference is still processed; a second result then
// waits until the output register is free.
module clock_page_replacement
   import crp_pkg::*;
#(
   parameter int NUM_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   cmd_type    cmd;
   status_type status;

   // The controller decides which step runs in each cycle.
   crp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds all frame state and the output register.
   crp_datapath #(
      .NUM_FRAMES(NUM_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_data   (req_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .cmd        (cmd),
      .status     (status)
   );

   // Only one step command may be active in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.scan_next, cmd.hit_done, cmd.sweep, cmd.load, cmd.emit}))
      else $error("more than one datapath command active");

   // Once a reference is accepted, no further one is taken until it is done.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request accepted while a reference is in work");

   // A result handed to the output register is presented in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

   // A finished lookup only hands off after a hit or a load.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.hit_done || cmd.load) |=> !req_stall || !cmd.start)
      else $error("lookup finished without reaching the result stage");

endmodule

// ----- design/crp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module crp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/crp_ctrl.sv -----
// Controller state machine that sequences the search, the sweep and the result hand-off.
module crp_ctrl
   import crp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.match) state_in = ST_RESULT;
            else if (status.scan_end) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!status.ref_set) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.hit_done  = status.match;
            cmd.scan_next = !status.match && !status.scan_end;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_RESULT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- design/crp_datapath.sv -----
// Datapath with the frame store, reference and valid bits, clock hand, fault counter and output register.
module crp_datapath
   import crp_pkg::*;
#(
   parameter int NUM_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  req_type          req_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
   localparam int CMP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int KEEP_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

   logic [CSR_W-1:0]      csr_frames_ff, csr_frames_in;
   logic [KEEP_W-1:0]     page_ff, page_in;
   logic                  last_ff, last_in;
   logic [IDX_W-1:0]      hand_ff, hand_in;
   logic [IDX_W-1:0]      cmp_ff, cmp_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [NUM_FRAMES-1:0] ref_ff, ref_in;
   logic [FAULT_W-1:0]    faults_ff, faults_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CMP_W-1:0]  csr_ext, limit, count;
   logic [IDX_W-1:0]  last_idx, hand_next, cmp_next, rd_addr;
   logic [KEEP_W-1:0] rd_data;
   logic [FAULT_W-1:0] faults_inc;

   // Effective frame count: zero counts as one, and it never exceeds the built size.
   always_comb begin
      csr_ext = CMP_W'(csr_frames_ff);
      limit   = CMP_W'(NUM_FRAMES);
      if (csr_ext == '0) count = CMP_W'(1);
      else if (csr_ext > limit) count = limit;
      else count = csr_ext;
      last_idx = IDX_W'(count - CMP_W'(1));
   end

   assign hand_next  = (hand_ff == last_idx) ? '0 : hand_ff + IDX_W'(1);
   assign cmp_next   = cmp_ff + IDX_W'(1);
   assign faults_inc = (faults_ff != FAULT_MAX) ? faults_ff + FAULT_W'(1) : faults_ff;

   always_comb begin
      if (cmd.start) rd_addr = '0;
      else if (cmd.scan_next) rd_addr = cmp_next;
      else rd_addr = hand_ff;
   end

   crp_ram #(
      .WIDTH(KEEP_W),
      .DEPTH(NUM_FRAMES)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (cmd.load),
      .wr_addr(hand_ff),
      .wr_data(page_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      status.match    = valid_ff[cmp_ff] && (rd_data == page_ff);
      status.scan_end = (cmp_ff == last_idx);
      status.ref_set  = ref_ff[hand_ff];
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      csr_frames_in = csr_wr_en ? csr_wr_data : csr_frames_ff;
      page_in       = page_ff;
      last_in       = last_ff;
      hand_in       = hand_ff;
      cmp_in        = cmp_ff;
      valid_in      = valid_ff;
      ref_in        = ref_ff;
      faults_in     = faults_ff;
      res_in        = res_ff;

      if (cmd.start) begin
         page_in = req_data.page_number[KEEP_W-1:0];
         last_in = req_data.last_reference;
         cmp_in  = '0;
         // A lowered frame count may leave the hand beyond the last frame.
         if (CMP_W'(hand_ff) >= count) hand_in = '0;
      end

      if (cmd.scan_next) cmp_in = cmp_next;

      if (cmd.sweep && ref_ff[hand_ff]) begin
         ref_in[hand_ff] = 1'b0;
         hand_in         = hand_next;
      end

      if (cmd.hit_done) begin
         ref_in[cmp_ff]       = 1'b1;
         res_in.hit           = 1'b1;
         res_in.slot          = SLOT_W'(cmp_ff);
         res_in.evicted_valid = 1'b0;
         res_in.evicted_page  = '0;
         res_in.fault_count   = faults_ff;
         res_in.last_result   = last_ff;
      end

      if (cmd.load) begin
         valid_in[hand_ff]    = 1'b1;
         ref_in[hand_ff]      = 1'b0;
         hand_in              = hand_next;
         faults_in            = faults_inc;
         res_in.hit           = 1'b0;
         res_in.slot          = SLOT_W'(hand_ff);
         res_in.evicted_valid = valid_ff[hand_ff];
         res_in.evicted_page  = valid_ff[hand_ff] ? PAGE_W'(rd_data) : '0;
         res_in.fault_count   = faults_inc;
         res_in.last_result   = last_ff;
      end

      // The end of a reference string returns every frame to empty.
      if ((cmd.hit_done || cmd.load) && last_ff) begin
         valid_in  = '0;
         ref_in    = '0;
         hand_in   = '0;
         faults_in = '0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_frames_ff <= CSR_FRAMES_RESET;
         hand_ff       <= '0;
         valid_ff      <= '0;
         ref_ff        <= '0;
         faults_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         csr_frames_ff <= csr_frames_in;
         hand_ff       <= hand_in;
         valid_ff      <= valid_in;
         ref_ff        <= ref_in;
         faults_ff     <= faults_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      last_ff <= last_in;
      cmp_ff  <= cmp_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
